FILE: rtl/rvdec_pkg.sv
// Package for the RV64IM decode stage: item structs, opcodes, class codes.
// No dependencies; used by rvdec_decode and rv64im_decode_with_hazard_check.
`timescale 1ns / 1ps

package rvdec_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_OP32     = 7'h3B;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;
    // shift funct6 codes (RV64 immediate shifts)
    localparam logic [5:0] F6_LOGICAL = 6'h00;
    localparam logic [5:0] F6_ARITH   = 6'h10;

    // funct3 codes used by name
    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_SLT   = 3'd2;
    localparam logic [2:0] F3_SLTU  = 3'd3;
    localparam logic [2:0] F3_XOR   = 3'd4;
    localparam logic [2:0] F3_SR    = 3'd5;
    localparam logic [2:0] F3_OR    = 3'd6;
    localparam logic [2:0] F3_AND   = 3'd7;

    localparam int CLS_W = 6;

    // Instruction classes (dense numbering)
    localparam logic [CLS_W-1:0] CLS_ADDI   = 6'd0;
    localparam logic [CLS_W-1:0] CLS_SLTI   = 6'd1;
    localparam logic [CLS_W-1:0] CLS_SLTIU  = 6'd2;
    localparam logic [CLS_W-1:0] CLS_XORI   = 6'd3;
    localparam logic [CLS_W-1:0] CLS_ORI    = 6'd4;
    localparam logic [CLS_W-1:0] CLS_ANDI   = 6'd5;
    localparam logic [CLS_W-1:0] CLS_SLLI   = 6'd6;
    localparam logic [CLS_W-1:0] CLS_SRLI   = 6'd7;
    localparam logic [CLS_W-1:0] CLS_SRAI   = 6'd8;
    localparam logic [CLS_W-1:0] CLS_LB     = 6'd9;
    localparam logic [CLS_W-1:0] CLS_ADDIW  = 6'd16;
    localparam logic [CLS_W-1:0] CLS_SLLIW  = 6'd17;
    localparam logic [CLS_W-1:0] CLS_SRLIW  = 6'd18;
    localparam logic [CLS_W-1:0] CLS_SRAIW  = 6'd19;
    localparam logic [CLS_W-1:0] CLS_JALR   = 6'd20;
    localparam logic [CLS_W-1:0] CLS_SB     = 6'd21;
    localparam logic [CLS_W-1:0] CLS_BEQ    = 6'd25;
    localparam logic [CLS_W-1:0] CLS_BNE    = 6'd26;
    localparam logic [CLS_W-1:0] CLS_BLT    = 6'd27;
    localparam logic [CLS_W-1:0] CLS_LUI    = 6'd31;
    localparam logic [CLS_W-1:0] CLS_AUIPC  = 6'd32;
    localparam logic [CLS_W-1:0] CLS_JAL    = 6'd33;
    localparam logic [CLS_W-1:0] CLS_ADD    = 6'd34;
    localparam logic [CLS_W-1:0] CLS_SUB    = 6'd42;
    localparam logic [CLS_W-1:0] CLS_SRA    = 6'd43;
    localparam logic [CLS_W-1:0] CLS_MUL    = 6'd44;
    localparam logic [CLS_W-1:0] CLS_ADDW   = 6'd52;
    localparam logic [CLS_W-1:0] CLS_SUBW   = 6'd53;
    localparam logic [CLS_W-1:0] CLS_SLLW   = 6'd54;
    localparam logic [CLS_W-1:0] CLS_SRLW   = 6'd55;
    localparam logic [CLS_W-1:0] CLS_SRAW   = 6'd56;
    localparam logic [CLS_W-1:0] CLS_MULW   = 6'd57;
    localparam logic [CLS_W-1:0] CLS_DIVW   = 6'd58;

    typedef struct packed {
        logic [31:0] instruction_word;
        logic [63:0] fetch_pc;
        logic        bubble;
        logic [4:0]  execute_dest;
        logic [4:0]  memory_dest;
    } t_in_item;

    typedef struct packed {
        logic [CLS_W-1:0]   inst_class;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        instruction_out;
        logic [63:0]        pc_out;
        logic               stall_res;
    } t_out_item;

    // Decoded fields handed from the decoder to the pipeline
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [4:0]       rd;
        logic [4:0]       rs1;
        logic [4:0]       rs2;
        logic [31:0]      imm;
    } t_dec;

endpackage

FILE: rtl/rvdec_decode.sv
// Combinational RV64IM field decoder: class, register fields, immediate.
// Depends on rvdec_pkg.
`timescale 1ns / 1ps

module rvdec_decode import rvdec_pkg::*; (
    input  logic [31:0] i_word,
    output t_dec        o_dec
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic        known;
    logic [CLS_W-1:0] cls;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] imm;

    assign opc = i_word[6:0];
    assign f3  = i_word[14:12];
    assign f7  = i_word[31:25];
    assign f6  = i_word[31:26];

    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};
    assign imm_u = {i_word[31:12], 12'h000};

    always_comb begin
        known = 1'b0;
        cls   = CLS_ADDI;
        rd    = 5'd0;
        rs1   = 5'd0;
        rs2   = 5'd0;
        imm   = 32'd0;
        unique case (opc)
            OPC_OP_IMM: begin
                rd = i_word[11:7]; rs1 = i_word[19:15]; imm = imm_i;
                known = 1'b1;
                case (f3)
                    F3_ADD:  cls = CLS_ADDI;
                    F3_SLT:  cls = CLS_SLTI;
                    F3_SLTU: cls = CLS_SLTIU;
                    F3_XOR:  cls = CLS_XORI;
                    F3_OR:   cls = CLS_ORI;
                    F3_AND:  cls = CLS_ANDI;
                    F3_SLL: begin
                        cls   = CLS_SLLI;
                        known = (f6 == F6_LOGICAL);
                    end
                    default: begin
                        cls   = (f6 == F6_ARITH) ? CLS_SRAI : CLS_SRLI;
                        known = (f6 == F6_LOGICAL) || (f6 == F6_ARITH);
                    end
                endcase
            end
            OPC_LOAD: begin
                rd = i_word[11:7]; rs1 = i_word[19:15]; imm = imm_i;
                cls   = CLS_LB + {3'b000, f3};
                known = (f3 != F3_AND);
            end
            OPC_OP_IMM32: begin
                rd = i_word[11:7]; rs1 = i_word[19:15]; imm = imm_i;
                if (f3 == F3_ADD) begin
                    cls = CLS_ADDIW; known = 1'b1;
                end else if (f3 == F3_SLL && f7 == F7_BASE) begin
                    cls = CLS_SLLIW; known = 1'b1;
                end else if (f3 == F3_SR && f7 == F7_BASE) begin
                    cls = CLS_SRLIW; known = 1'b1;
                end else if (f3 == F3_SR && f7 == F7_ALT) begin
                    cls = CLS_SRAIW; known = 1'b1;
                end
            end
            OPC_JALR: begin
                rd = i_word[11:7]; rs1 = i_word[19:15]; imm = imm_i;
                cls   = CLS_JALR;
                known = (f3 == F3_ADD);
            end
            OPC_STORE: begin
                rs1 = i_word[19:15]; rs2 = i_word[24:20]; imm = imm_s;
                cls   = CLS_SB + {3'b000, f3};
                known = !f3[2];
            end
            OPC_BRANCH: begin
                rs1 = i_word[19:15]; rs2 = i_word[24:20]; imm = imm_b;
                if (f3[2]) begin
                    cls = CLS_BLT + {4'b0000, f3[1:0]}; known = 1'b1;
                end else if (!f3[1]) begin
                    cls = f3[0] ? CLS_BNE : CLS_BEQ; known = 1'b1;
                end
            end
            OPC_LUI: begin
                rd = i_word[11:7]; imm = imm_u; cls = CLS_LUI; known = 1'b1;
            end
            OPC_AUIPC: begin
                rd = i_word[11:7]; imm = imm_u; cls = CLS_AUIPC; known = 1'b1;
            end
            OPC_JAL: begin
                rd = i_word[11:7]; imm = imm_j; cls = CLS_JAL; known = 1'b1;
            end
            OPC_OP: begin
                rd = i_word[11:7]; rs1 = i_word[19:15]; rs2 = i_word[24:20];
                if (f7 == F7_BASE) begin
                    cls = CLS_ADD + {3'b000, f3}; known = 1'b1;
                end else if (f7 == F7_MULDIV) begin
                    cls = CLS_MUL + {3'b000, f3}; known = 1'b1;
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    cls = CLS_SUB; known = 1'b1;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    cls = CLS_SRA; known = 1'b1;
                end
            end
            OPC_OP32: begin
                rd = i_word[11:7]; rs1 = i_word[19:15]; rs2 = i_word[24:20];
                if (f7 == F7_BASE) begin
                    if (f3 == F3_ADD) begin
                        cls = CLS_ADDW; known = 1'b1;
                    end else if (f3 == F3_SLL) begin
                        cls = CLS_SLLW; known = 1'b1;
                    end else if (f3 == F3_SR) begin
                        cls = CLS_SRLW; known = 1'b1;
                    end
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) begin
                        cls = CLS_SUBW; known = 1'b1;
                    end else if (f3 == F3_SR) begin
                        cls = CLS_SRAW; known = 1'b1;
                    end
                end else if (f7 == F7_MULDIV) begin
                    if (f3 == F3_ADD) begin
                        cls = CLS_MULW; known = 1'b1;
                    end else if (f3[2]) begin
                        cls = CLS_DIVW + {4'b0000, f3[1:0]}; known = 1'b1;
                    end
                end
            end
            default: known = 1'b0;
        endcase
    end

    // Unknown encodings collapse to addi x0, x0, 0
    always_comb begin
        if (known) begin
            o_dec = '{cls: cls, rd: rd, rs1: rs1, rs2: rs2, imm: imm};
        end else begin
            o_dec = '{cls: CLS_ADDI, rd: 5'd0, rs1: 5'd0, rs2: 5'd0, imm: 32'd0};
        end
    end

endmodule

FILE: rtl/rv64im_decode_with_hazard_check.sv
// Top level of the RV64IM decode stage with read-after-write hazard check.
// Depends on rvdec_pkg and rvdec_decode.
`timescale 1ns / 1ps
//
//  channel   handshake            payload     direction
//  -------   ------------------   ---------   ---------
//  command   start / busy         i_item      in
//  result    o_valid (strobe)     o_result    out
//
//  Three register stages (capture, decode, hazard compare): the result strobe
//  rises as an item reaches the output register; one item can enter on every
//  clock.
//  busy is held low: every stage advances on every clock.
//  Reset (i_rst_n low, synchronous) clears the stage valid bits only.
//  The receiver cannot stall; a result is on o_result for one cycle only.
//  Bubbles and all-zero words are dropped at capture and give no result.

module rv64im_decode_with_hazard_check import rvdec_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    // Stage 1: capture
    logic        r_s1_vld, n_s1_vld;
    logic [31:0] r_s1_word;
    logic [63:0] r_s1_pc;
    logic [4:0]  r_s1_xd, r_s1_md;

    // Stage 2: decoded fields
    logic        r_s2_vld;
    t_dec        r_s2_dec;
    logic [31:0] r_s2_word;
    logic [63:0] r_s2_pc;
    logic [4:0]  r_s2_xd, r_s2_md;

    // Stage 3: output register
    logic        r_s3_vld;
    t_out_item   r_s3_res, n_s3_res;

    t_dec        s1_dec;
    logic        hit1, hit2;

    // No back-pressure anywhere in the pipe
    assign busy = 1'b0;

    // Drop bubbles and the all-zero word right at the door
    assign n_s1_vld = start && !busy && !i_item.bubble &&
                      (i_item.instruction_word != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Payload registers: load every cycle, valid bits say what is real
    always_ff @(posedge i_clk) begin
        r_s1_word <= i_item.instruction_word;
        r_s1_pc   <= i_item.fetch_pc;
        r_s1_xd   <= i_item.execute_dest;
        r_s1_md   <= i_item.memory_dest;

        r_s2_dec  <= s1_dec;
        r_s2_word <= r_s1_word;
        r_s2_pc   <= r_s1_pc;
        r_s2_xd   <= r_s1_xd;
        r_s2_md   <= r_s1_md;

        r_s3_res  <= n_s3_res;
    end

    rvdec_decode u_decode (
        .i_word (r_s1_word),
        .o_dec  (s1_dec)
    );

    // Hazard: a nonzero source that matches either later-stage destination.
    // Unused sources were already forced to x0 by the decoder.
    assign hit1 = (r_s2_dec.rs1 != 5'd0) &&
                  ((r_s2_dec.rs1 == r_s2_xd) || (r_s2_dec.rs1 == r_s2_md));
    assign hit2 = (r_s2_dec.rs2 != 5'd0) &&
                  ((r_s2_dec.rs2 == r_s2_xd) || (r_s2_dec.rs2 == r_s2_md));

    always_comb begin
        n_s3_res.inst_class      = r_s2_dec.cls;
        n_s3_res.dest_reg        = r_s2_dec.rd;
        n_s3_res.src1_reg        = r_s2_dec.rs1;
        n_s3_res.src2_reg        = r_s2_dec.rs2;
        n_s3_res.immediate       = r_s2_dec.imm;
        n_s3_res.instruction_out = r_s2_word;
        n_s3_res.pc_out          = r_s2_pc;
        n_s3_res.stall_res       = hit1 || hit2;
    end

    assign o_valid  = r_s3_vld;
    assign o_result = r_s3_res;

`ifndef SYNTH
    // A result strobe always traces back to a decoded item in the cycle before
    a_strobe_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> $past(r_s2_vld))
        else $error("result strobe without a decoded item behind it");

    // A stall never comes from x0 sources alone
    a_stall_needs_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.stall_res) |->
            ((o_result.src1_reg != 5'd0) || (o_result.src2_reg != 5'd0)))
        else $error("stall raised with both sources x0");

    // The all-zero word is never reported
    a_zero_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.instruction_word == 32'd0)) |-> ##3 !o_valid)
        else $error("all-zero instruction produced a result");

    // Every accepted real item comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_s1_vld |-> ##3 o_valid)
        else $error("accepted item lost in the pipe");
`endif

endmodule

FILE: verif/rv64im_decode_with_hazard_check_test.sv
// Self-checking testbench for the RV64IM decode stage with its hazard check.
// Needs rvdec_pkg and the rv64im_decode_with_hazard_check RTL. Decode results are
// predicted here and compared field by field.
`timescale 1ns / 1ps

module rv64im_decode_with_hazard_check_test import rvdec_pkg::*; ;

    // Use these funct3 values by name in the directed items.
    localparam logic [2:0] F3_DWORD    = 3'd3;  // ld / sd
    localparam logic [2:0] F3_NOSTORE  = 3'd4;  // first store funct3 with no opcode
    localparam logic [2:0] F3_NOBRANCH = 3'd2;  // branch funct3 hole
    localparam logic [2:0] F3_TOP      = 3'd7;  // bgeu; no load here
    localparam int         TARGET_RESULTS = 1800;
    localparam int         DRAIN_CYCLES   = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_valid;
    t_out_item o_result;

    t_in_item  pending[$];       // items waiting to be offered to the block
    t_out_item decodes_due[$];   // predicted decodes, oldest first
    t_out_item predicted;        // driver side: decode of the item just accepted
    t_out_item next_decode;      // monitor side: prediction being compared
    int        total_items = 0;
    int        accepted_cnt = 0;
    int        checked_cnt = 0;
    int        stall_cnt = 0;
    int        error_cnt = 0;
    logic [63:0] classes_seen = '0;

    rv64im_decode_with_hazard_check DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Assemble a 32-bit word from the R-type field slots; every format's bits
    // sit in these same slots, so immediates are given through them too.
    function automatic logic [31:0] pack_word(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    // Predict the decode of one item. Return 0 when the block drops the item
    // (bubble or all-zero word), 1 when it gives a result in dec.
    function automatic bit decode_expect(input t_in_item it, output t_out_item dec);
        logic [31:0] w;
        logic [6:0]  op;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [CLS_W-1:0] cls;
        bit          known;

        w = it.instruction_word;
        dec = '0;
        if (it.bubble || w == 32'd0)
            return 1'b0;

        op = w[6:0];
        f3 = w[14:12];
        f7 = w[31:25];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        rd = '0;
        rs1 = '0;
        rs2 = '0;
        imm = '0;
        cls = CLS_ADDI;
        known = 1'b0;

        case (op)
            OPC_OP_IMM: begin
                known = 1'b1;
                case (f3)
                    F3_ADD:  cls = CLS_ADDI;
                    F3_SLT:  cls = CLS_SLTI;
                    F3_SLTU: cls = CLS_SLTIU;
                    F3_XOR:  cls = CLS_XORI;
                    F3_OR:   cls = CLS_ORI;
                    F3_AND:  cls = CLS_ANDI;
                    F3_SLL: begin
                        cls = CLS_SLLI;
                        known = (w[31:26] == F6_LOGICAL);
                    end
                    default: begin
                        // shift right: funct6 picks logical or arithmetic
                        if (w[31:26] == F6_LOGICAL)
                            cls = CLS_SRLI;
                        else if (w[31:26] == F6_ARITH)
                            cls = CLS_SRAI;
                        else
                            known = 1'b0;
                    end
                endcase
                rd = w[11:7]; rs1 = w[19:15]; imm = imm_i;
            end
            OPC_LOAD: begin
                known = (f3 != F3_TOP);
                cls = CLS_LB + {3'b000, f3};
                rd = w[11:7]; rs1 = w[19:15]; imm = imm_i;
            end
            OPC_OP_IMM32: begin
                if (f3 == F3_ADD) begin
                    known = 1'b1; cls = CLS_ADDIW;
                end else if (f3 == F3_SLL && f7 == F7_BASE) begin
                    known = 1'b1; cls = CLS_SLLIW;
                end else if (f3 == F3_SR && f7 == F7_BASE) begin
                    known = 1'b1; cls = CLS_SRLIW;
                end else if (f3 == F3_SR && f7 == F7_ALT) begin
                    known = 1'b1; cls = CLS_SRAIW;
                end
                rd = w[11:7]; rs1 = w[19:15]; imm = imm_i;
            end
            OPC_JALR: begin
                known = (f3 == F3_ADD);
                cls = CLS_JALR;
                rd = w[11:7]; rs1 = w[19:15]; imm = imm_i;
            end
            OPC_STORE: begin
                known = (f3 < F3_NOSTORE);
                cls = CLS_SB + {3'b000, f3};
                rs1 = w[19:15]; rs2 = w[24:20]; imm = imm_s;
            end
            OPC_BRANCH: begin
                if (f3 < F3_NOBRANCH) begin
                    known = 1'b1; cls = CLS_BEQ + {3'b000, f3};
                end else if (f3 >= F3_XOR) begin
                    known = 1'b1; cls = CLS_BLT + {3'b000, 3'(f3 - F3_XOR)};
                end
                rs1 = w[19:15]; rs2 = w[24:20]; imm = imm_b;
            end
            OPC_LUI: begin
                known = 1'b1; cls = CLS_LUI;
                rd = w[11:7]; imm = {w[31:12], 12'd0};
            end
            OPC_AUIPC: begin
                known = 1'b1; cls = CLS_AUIPC;
                rd = w[11:7]; imm = {w[31:12], 12'd0};
            end
            OPC_JAL: begin
                known = 1'b1; cls = CLS_JAL;
                rd = w[11:7]; imm = imm_j;
            end
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    known = 1'b1; cls = CLS_ADD + {3'b000, f3};
                end else if (f7 == F7_MULDIV) begin
                    known = 1'b1; cls = CLS_MUL + {3'b000, f3};
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    known = 1'b1; cls = CLS_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    known = 1'b1; cls = CLS_SRA;
                end
                rd = w[11:7]; rs1 = w[19:15]; rs2 = w[24:20];
            end
            OPC_OP32: begin
                if (f7 == F7_BASE) begin
                    if (f3 == F3_ADD) begin
                        known = 1'b1; cls = CLS_ADDW;
                    end else if (f3 == F3_SLL) begin
                        known = 1'b1; cls = CLS_SLLW;
                    end else if (f3 == F3_SR) begin
                        known = 1'b1; cls = CLS_SRLW;
                    end
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_ADD) begin
                        known = 1'b1; cls = CLS_SUBW;
                    end else if (f3 == F3_SR) begin
                        known = 1'b1; cls = CLS_SRAW;
                    end
                end else if (f7 == F7_MULDIV) begin
                    if (f3 == F3_ADD) begin
                        known = 1'b1; cls = CLS_MULW;
                    end else if (f3 >= F3_XOR) begin
                        known = 1'b1; cls = CLS_DIVW + {3'b000, 3'(f3 - F3_XOR)};
                    end
                end
                rd = w[11:7]; rs1 = w[19:15]; rs2 = w[24:20];
            end
            default: known = 1'b0;
        endcase

        // Unknown encodings turn into a plain nop, which is still compared.
        if (!known) begin
            cls = CLS_ADDI; rd = '0; rs1 = '0; rs2 = '0; imm = '0;
        end

        dec.inst_class      = cls;
        dec.dest_reg        = rd;
        dec.src1_reg        = rs1;
        dec.src2_reg        = rs2;
        dec.immediate       = imm;
        dec.instruction_out = w;
        dec.pc_out          = it.fetch_pc;
        dec.stall_res = (rs1 != 5'd0 && (rs1 == it.execute_dest || rs1 == it.memory_dest)) ||
                        (rs2 != 5'd0 && (rs2 == it.execute_dest || rs2 == it.memory_dest));
        return 1'b1;
    endfunction

    task automatic add_item(input logic [31:0] w, input logic [63:0] pc, input logic bub,
                            input logic [4:0] ex_rd, input logic [4:0] mem_rd);
        t_in_item it;
        it.instruction_word = w;
        it.fetch_pc         = pc;
        it.bubble           = bub;
        it.execute_dest     = ex_rd;
        it.memory_dest      = mem_rd;
        pending.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_cnt++;
        end
    endtask

    // Driver: offer the next item from the pending queue, hold it while busy,
    // and predict its decode at the edge that accepts it. The sender idles
    // 11% of the time in the first third, 84% in the second, never in the last.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                accepted_cnt++;
                if (decode_expect(i_item, predicted))
                    decodes_due.push_back(predicted);
            end
            if (!start || !busy) begin
                if (pending.size() != 0 &&
                    $urandom_range(99) >= (accepted_cnt < total_items / 3 ? 11 :
                                           accepted_cnt < 2 * total_items / 3 ? 84 : 0)) begin
                    i_item <= pending.pop_front();
                    start  <= 1'b1;
                end else begin
                    start  <= 1'b0;
                end
            end
        end
    end

    // Monitor: take every strobed result and compare it with the oldest
    // prediction. The receiver has no back-pressure, so nothing to drive here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (decodes_due.size() == 0) begin
                $error("unexpected result: class %0d pc 0x%0h word 0x%08h",
                       o_result.inst_class, o_result.pc_out, o_result.instruction_out);
                error_cnt++;
            end else begin
                next_decode = decodes_due.pop_front();
                check_field("inst_class", 64'(next_decode.inst_class),
                            64'(o_result.inst_class));
                check_field("dest_reg", 64'(next_decode.dest_reg), 64'(o_result.dest_reg));
                check_field("src1_reg", 64'(next_decode.src1_reg), 64'(o_result.src1_reg));
                check_field("src2_reg", 64'(next_decode.src2_reg), 64'(o_result.src2_reg));
                check_field("immediate", 64'(next_decode.immediate),
                            64'(o_result.immediate));
                check_field("instruction_out", 64'(next_decode.instruction_out),
                            64'(o_result.instruction_out));
                check_field("pc_out", next_decode.pc_out, o_result.pc_out);
                check_field("stall_res", 64'(next_decode.stall_res),
                            64'(o_result.stall_res));
                checked_cnt++;
                if (next_decode.stall_res)
                    stall_cnt++;
                classes_seen[next_decode.inst_class] = 1'b1;
            end
        end
    end

    initial begin
        t_in_item   probe;
        t_out_item  scratch;
        int         made;
        int         roll;
        logic [6:0] op;
        logic [6:0] f7;
        logic [31:0] w;
        logic [4:0]  dests [2];

        // Directed items: dropped slots, unknown encodings, immediate extremes,
        // the funct7/funct6 selections and the hazard corner cases.
        add_item(32'h0000_0000, 64'h0, 1'b0, 5'd0, 5'd0);               // all-zero word
        add_item(pack_word(7'h00, 5'd1, 5'd1, F3_ADD, 5'd1, OPC_OP_IMM),
                 '1, 1'b1, 5'd1, 5'd1);                                  // bubble
        add_item(32'hFFFF_FFFF, '1, 1'b0, 5'd31, 5'd31);                 // unknown opcode
        add_item(32'h0FF0_000F, 64'h0, 1'b0, 5'd0, 5'd0);                // fence
        add_item(32'h0000_0073, 64'h4, 1'b0, 5'd0, 5'd0);                // ecall
        add_item(pack_word(7'h7F, 5'h1F, 5'd2, F3_ADD, 5'd1, OPC_OP_IMM),
                 64'h8, 1'b0, 5'd2, 5'd0);                               // addi -1, ex hazard
        add_item(pack_word(7'h01, 5'h1F, 5'd3, F3_SLL, 5'd3, OPC_OP_IMM),
                 64'hC, 1'b0, 5'd0, 5'd3);                               // slli 63, mem hazard
        add_item(pack_word(7'h21, 5'h1F, 5'd4, F3_SR, 5'd4, OPC_OP_IMM),
                 64'h10, 1'b0, 5'd5, 5'd6);                              // srai 63
        add_item(pack_word(7'h30, 5'h01, 5'd4, F3_SR, 5'd4, OPC_OP_IMM),
                 64'h14, 1'b0, 5'd4, 5'd4);                              // bad shift funct6
        add_item(pack_word(7'h40, 5'd0, 5'd31, F3_DWORD, 5'd31, OPC_LOAD),
                 64'h18, 1'b0, 5'd0, 5'd31);                             // ld, min offset
        add_item(pack_word(7'h00, 5'd0, 5'd5, F3_TOP, 5'd6, OPC_LOAD),
                 64'h1C, 1'b0, 5'd5, 5'd5);                              // load hole
        add_item(pack_word(7'h3F, 5'd7, 5'd8, F3_DWORD, 5'h1F, OPC_STORE),
                 64'h20, 1'b0, 5'd7, 5'd0);                              // sd +2047, rs2 hazard
        add_item(pack_word(7'h00, 5'd7, 5'd8, F3_NOSTORE, 5'd0, OPC_STORE),
                 64'h24, 1'b0, 5'd7, 5'd8);                              // store hole
        add_item(pack_word(7'h7F, 5'd9, 5'd10, F3_TOP, 5'h1F, OPC_BRANCH),
                 64'h28, 1'b0, 5'd11, 5'd10);                            // bgeu -2
        add_item(pack_word(7'h3F, 5'd0, 5'd0, F3_ADD, 5'h1E, OPC_BRANCH),
                 64'h2C, 1'b0, 5'd0, 5'd0);                              // beq x0, x0 +2046
        add_item(pack_word(7'h00, 5'd1, 5'd2, F3_NOBRANCH, 5'd2, OPC_BRANCH),
                 64'h30, 1'b0, 5'd1, 5'd2);                              // branch hole
        add_item(pack_word(7'h7F, 5'h1F, 5'h1F, F3_AND, 5'd5, OPC_LUI),
                 64'h34, 1'b0, 5'd31, 5'd31);                            // lui all ones
        add_item(pack_word(7'h40, 5'd0, 5'd0, F3_ADD, 5'd6, OPC_AUIPC),
                 64'h38, 1'b0, 5'd0, 5'd0);                              // auipc sign bit
        add_item(pack_word(7'h7F, 5'h1F, 5'h1F, F3_AND, 5'd1, OPC_JAL),
                 64'h3C, 1'b0, 5'd31, 5'd31);                            // jal -2
        add_item(pack_word(7'h3F, 5'h1F, 5'h1F, F3_AND, 5'd1, OPC_JAL),
                 64'h40, 1'b0, 5'd1, 5'd1);                              // jal max forward
        add_item(pack_word(7'h40, 5'd0, 5'd1, F3_ADD, 5'd0, OPC_JALR),
                 64'h44, 1'b0, 5'd0, 5'd1);                              // jalr
        add_item(pack_word(F7_ALT, 5'h1F, 5'd12, F3_SR, 5'd12, OPC_OP_IMM32),
                 64'h48, 1'b0, 5'd12, 5'd0);                             // sraiw
        add_item(pack_word(7'h21, 5'h1F, 5'd12, F3_SR, 5'd12, OPC_OP_IMM32),
                 64'h4C, 1'b0, 5'd12, 5'd12);                            // sraiw, bad funct7
        add_item(pack_word(F7_ALT, 5'd13, 5'd14, F3_ADD, 5'd15, OPC_OP),
                 64'h50, 1'b0, 5'd14, 5'd13);                            // sub
        add_item(pack_word(F7_MULDIV, 5'd16, 5'd17, F3_AND, 5'd18, OPC_OP),
                 '1, 1'b0, 5'd16, 5'd0);                                 // remu
        add_item(pack_word(F7_ALT, 5'd16, 5'd17, F3_SLL, 5'd18, OPC_OP),
                 64'h58, 1'b0, 5'd16, 5'd17);                            // op hole
        add_item(pack_word(F7_MULDIV, 5'd19, 5'd20, F3_SR, 5'd21, OPC_OP32),
                 64'h5C, 1'b0, 5'd0, 5'd20);                             // divuw
        add_item(pack_word(F7_MULDIV, 5'd19, 5'd20, F3_SLL, 5'd21, OPC_OP32),
                 64'h60, 1'b0, 5'd19, 5'd20);                            // op32 hole

        // Random part: mostly well-formed words with random fields and funct7
        // biased to the legal values; some noise words, zero words and bubbles.
        // Hazard destinations are often taken from the word's own source fields.
        made = 0;
        while (made < TARGET_RESULTS) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                w = $urandom;
            end else if (roll < 10) begin
                w = 32'd0;
            end else begin
                case ($urandom_range(10))
                    0:  op = OPC_OP_IMM;
                    1:  op = OPC_LOAD;
                    2:  op = OPC_OP_IMM32;
                    3:  op = OPC_JALR;
                    4:  op = OPC_STORE;
                    5:  op = OPC_BRANCH;
                    6:  op = OPC_AUIPC;
                    7:  op = OPC_LUI;
                    8:  op = OPC_JAL;
                    9:  op = OPC_OP;
                    default: op = OPC_OP32;
                endcase
                roll = $urandom_range(9);
                f7 = roll < 3 ? F7_BASE : roll < 6 ? F7_MULDIV : roll < 8 ? F7_ALT
                                                               : 7'($urandom);
                w = $urandom;
                w = pack_word(f7, w[24:20], w[19:15], w[14:12], w[11:7], op);
            end
            for (int k = 0; k < 2; k++) begin
                roll = $urandom_range(3);
                dests[k] = roll == 0 ? w[19:15] : roll == 1 ? w[24:20] :
                           roll == 2 ? 5'd0 : 5'($urandom);
            end
            probe.instruction_word = w;
            probe.fetch_pc         = {$urandom, $urandom};
            probe.bubble           = ($urandom_range(99) < 5);
            probe.execute_dest     = dests[0];
            probe.memory_dest      = dests[1];
            pending.push_back(probe);
            // only items that give a result count toward the target
            if (decode_expect(probe, scratch))
                made++;
        end
        total_items = pending.size();

        // Hold reset, then let the driver run.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is in and every decode is back, then drain.
        while (accepted_cnt < total_items || decodes_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items sent, %0d decodes checked, %0d of them with a hazard stall",
                 total_items, checked_cnt, stall_cnt);
        $display("%0d of 62 instruction classes decoded", $countones(classes_seen));
        if (error_cnt == 0 && decodes_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
